@@ rtl/itoa_pkg.sv @@
// shared codes, constants, types and helpers for the integer to ascii converter
package itoa_pkg;

  // default converted value width
  localparam int VALUE_WIDTH_DEF = 64;

  // conversion selector codes
  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEX  = 3'd2;
  localparam logic [2:0] OP_OCT  = 3'd3;
  localparam logic [2:0] OP_BIN  = 3'd4;

  // digit size codes for the emitter
  localparam logic [1:0] DSZ_BIN = 2'd0;
  localparam logic [1:0] DSZ_OCT = 2'd1;
  localparam logic [1:0] DSZ_HEX = 2'd2;

  // ascii constants
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_MINUS     = 8'h2d;
  localparam logic [7:0] CHAR_ALPHA_OFS = 8'h57;
  localparam logic [3:0] DEC_RADIX      = 4'd10;

  // emitter load control
  typedef struct packed {
    logic       load;
    logic       neg;
    logic [1:0] dsz;
  } emit_ctrl_t;

  // one digit to its ascii character
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d >= DEC_RADIX) begin
      c = {4'h0, d} + CHAR_ALPHA_OFS;
    end else begin
      c = {4'h0, d} + CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

@@ rtl/integer_to_ascii_radix.sv @@
// integer to ascii text converter, top level
// One item takes a value and a selector and gives its text one character per item
// on the output, most significant first, with last marking the final character.
// Decimal runs through the bit-serial bcd unit, one value bit per cycle, then hands
// the digits to the emitter, which walks every digit position of the bcd register
// (leading zeros are walked past) after a minus sign for a negative signed value;
// hex, octal and binary go straight to the emitter, which walks their digit positions,
// ceil(VALUE_WIDTH/bits per digit) of them. Stalls on the output hold the walk.
module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last
);

  localparam int W     = VALUE_WIDTH;
  localparam int ND    = (W * 30103) / 100000 + 1;
  localparam int BCD_W = 4 * ND;
  localparam int NH    = (W + 3) / 4;
  localparam int NO    = (W + 2) / 3;
  localparam int RW0   = (BCD_W > 3 * NO) ? BCD_W : 3 * NO;
  localparam int RW    = (RW0 > 4 * NH) ? RW0 : 4 * NH;
  localparam int CW    = $clog2(RW + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  logic                 neg_q;
  logic                 accept;
  logic [W-1:0]         vw;
  logic                 is_neg;
  logic [W-1:0]         mag;
  logic                 op_dec;
  logic                 op_pow2;
  logic [RW-1:0]        top_val;
  logic                 dab_done;
  logic [BCD_W-1:0]     bcd;
  logic                 emit_busy;
  itoa_pkg::emit_ctrl_t emit_ctrl;
  logic [RW-1:0]        load_data;
  logic [CW-1:0]        load_count;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // input decode and magnitude
  always_comb begin
    vw      = value[W-1:0];
    op_dec  = (opcode == itoa_pkg::OP_SDEC) || (opcode == itoa_pkg::OP_UDEC);
    op_pow2 = (opcode == itoa_pkg::OP_HEX) || (opcode == itoa_pkg::OP_OCT) ||
              (opcode == itoa_pkg::OP_BIN);
    is_neg  = (opcode == itoa_pkg::OP_SDEC) && vw[W-1];
    mag     = is_neg ? (~vw + W'(1)) : vw;
    top_val = RW'(vw) << (RW - W);
  end

  // emitter load selection
  always_comb begin
    emit_ctrl.load = 1'b0;
    emit_ctrl.neg  = 1'b0;
    emit_ctrl.dsz  = itoa_pkg::DSZ_HEX;
    load_data      = top_val;
    load_count     = CW'(NH);
    if (state == ST_CONV) begin
      emit_ctrl.load = dab_done;
      emit_ctrl.neg  = neg_q;
      load_data      = RW'(bcd) << (RW - BCD_W);
      load_count     = CW'(ND);
    end else begin
      emit_ctrl.load = accept && op_pow2;
      case (opcode)
        itoa_pkg::OP_OCT: begin
          emit_ctrl.dsz = itoa_pkg::DSZ_OCT;
          load_data     = top_val >> (3 * NO - W);
          load_count    = CW'(NO);
        end
        itoa_pkg::OP_BIN: begin
          emit_ctrl.dsz = itoa_pkg::DSZ_BIN;
          load_data     = top_val;
          load_count    = CW'(W);
        end
        default: begin
          emit_ctrl.dsz = itoa_pkg::DSZ_HEX;
          load_data     = top_val >> (4 * NH - W);
          load_count    = CW'(NH);
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && op_dec) begin
          state_next = ST_CONV;
        end else if (accept && op_pow2) begin
          state_next = ST_EMIT;
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_q <= is_neg;
    end
  end

  itoa_dabble #(
    .W  (W),
    .ND (ND)
  ) u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (accept && op_dec),
    .mag   (mag),
    .done  (dab_done),
    .bcd   (bcd)
  );

  itoa_emit #(
    .RW (RW),
    .CW (CW)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (emit_ctrl),
    .load_data  (load_data),
    .load_count (load_count),
    .busy       (emit_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .last       (last)
  );

  // checks
  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !emit_busy)
    else $error("input open while emitter busy");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    dab_done |-> (state == ST_CONV))
    else $error("bcd done outside conversion");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    emit_ctrl.load |-> !emit_busy)
    else $error("emitter loaded while busy");

  a_busy_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(emit_busy) |-> $past(emit_ctrl.load))
    else $error("emitter started without load");

endmodule

@@ rtl/itoa_dabble.sv @@
// bit-serial binary to bcd conversion unit, one input bit per cycle
module itoa_dabble #(
  parameter int W  = itoa_pkg::VALUE_WIDTH_DEF,
  parameter int ND = 20
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [W-1:0]    mag,
  output logic            done,
  output logic [4*ND-1:0] bcd
);

  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    sh;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [4*ND-1:0] adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= mag;
      bcd <= '0;
    end else if (busy) begin
      sh  <= sh << 1;
      bcd <= {adj[4*ND-2:0], sh[W-1]};
    end
  end

endmodule

@@ rtl/itoa_emit.sv @@
// character emitter: walks the digit register msb first into the output register
module itoa_emit #(
  parameter int RW = 80,
  parameter int CW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  itoa_pkg::emit_ctrl_t ctrl,
  input  logic [RW-1:0]        load_data,
  input  logic [CW-1:0]        load_count,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_char,
  output logic                 last
);

  logic [RW-1:0] r;
  logic [CW-1:0] n;
  logic [1:0]    dsz;
  logic          neg_pend;
  logic          started;

  logic          advance;
  logic [3:0]    digit;
  logic [RW-1:0] r_next;
  logic          skip;
  logic          emit;
  logic [7:0]    char_next;
  logic          last_next;

  assign advance = busy && (!out_valid || !out_stall);

  // top digit and shifted register
  always_comb begin
    case (dsz)
      itoa_pkg::DSZ_BIN: begin
        digit  = {3'b000, r[RW-1]};
        r_next = r << 1;
      end
      itoa_pkg::DSZ_OCT: begin
        digit  = {1'b0, r[RW-1 -: 3]};
        r_next = r << 3;
      end
      default: begin
        digit  = r[RW-1 -: 4];
        r_next = r << 4;
      end
    endcase
  end

  // leading zeros are dropped, the last digit always goes out
  always_comb begin
    skip      = !neg_pend && !started && (digit == 4'd0) && (n != CW'(1));
    emit      = advance && !skip;
    char_next = neg_pend ? itoa_pkg::CHAR_MINUS : itoa_pkg::digit_char(digit);
    last_next = !neg_pend && (n == CW'(1));
  end

  // walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      neg_pend <= 1'b0;
      started  <= 1'b0;
    end else if (ctrl.load) begin
      busy     <= 1'b1;
      neg_pend <= ctrl.neg;
      started  <= 1'b0;
    end else if (advance) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else begin
        if (!skip) begin
          started <= 1'b1;
        end
        if (n == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // digit register and count
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      r   <= load_data;
      n   <= load_count;
      dsz <= ctrl.dsz;
    end else if (advance && !neg_pend) begin
      r <= r_next;
      n <= n - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= char_next;
      last     <= last_next;
    end
  end

endmodule
